// File: rtl/tcsum_pkg.sv
// ----------------------------------------------------------------------------
// tcsum_pkg
// Shared types, constants and the ones'-complement add for the checksum engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcsum_pkg;

  localparam int unsigned IdxW = 4;

  localparam logic [IdxW-1:0] IDX_SAT      = 4'd9;
  localparam logic [IdxW-1:0] IP_CSUM_POS  = 4'd5;
  localparam logic [IdxW-1:0] TCP_CSUM_POS = 4'd8;

  localparam logic [15:0] PROTO_TCP = 16'h0006;
  localparam logic [15:0] MASK16    = 16'hffff;
  localparam logic [15:0] ZERO16    = 16'h0000;
  localparam logic [15:0] ODD_MASK  = 16'hff00;

  localparam logic MODE_IP  = 1'b0;
  localparam logic MODE_TCP = 1'b1;

  // one request held in the input register, with its pseudo-header sum
  typedef struct packed {
    logic        op;
    logic        first;
    logic [15:0] data_word;
    logic        last;
    logic        odd_tail;
    logic [15:0] phdr_sum;
  } stage_t;

  // 16-bit ones'-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/tcsum_front.sv
// ----------------------------------------------------------------------------
// tcsum_front
// Input register; folds the TCP pseudo-header into 16 bits on the way in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcsum_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 op_i,
  input  wire logic                 first_i,
  input  wire logic [15:0]          data_word_i,
  input  wire logic                 last_i,
  input  wire logic                 odd_tail_i,
  input  wire logic [31:0]          src_addr_i,
  input  wire logic [31:0]          dst_addr_i,
  input  wire logic [15:0]          seg_len_i,
  input  wire logic                 take_i,
  output logic                      stage_valid_o,
  output tcsum_pkg::stage_t         stage_o
);

  logic              valid_q, valid_d;
  tcsum_pkg::stage_t item_q, item_d;
  logic              load;
  logic [18:0]       phdr_wide;
  logic [16:0]       phdr_f1;
  logic [15:0]       phdr_f2;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  // six 16-bit terms summed wide, then folded twice
  always_comb begin
    phdr_wide = {3'd0, src_addr_i[31:16]} + {3'd0, src_addr_i[15:0]}
              + {3'd0, dst_addr_i[31:16]} + {3'd0, dst_addr_i[15:0]}
              + {3'd0, tcsum_pkg::PROTO_TCP} + {3'd0, seg_len_i};
    phdr_f1   = {1'b0, phdr_wide[15:0]} + {14'd0, phdr_wide[18:16]};
    phdr_f2   = phdr_f1[15:0] + {15'd0, phdr_f1[16]};
  end

  always_comb begin
    item_d           = item_q;
    item_d.op        = op_i;
    item_d.first     = first_i;
    item_d.data_word = data_word_i;
    item_d.last      = last_i;
    item_d.odd_tail  = odd_tail_i;
    item_d.phdr_sum  = (op_i == tcsum_pkg::MODE_TCP) ? phdr_f2 : tcsum_pkg::ZERO16;
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_o       = item_q;

endmodule

`default_nettype wire

// File: rtl/tcsum_accum.sv
// ----------------------------------------------------------------------------
// tcsum_accum
// Running ones'-complement sum, word position, mode, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcsum_accum (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 stage_valid_i,
  input  wire tcsum_pkg::stage_t    stage_i,
  output logic                      take_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [15:0]               checksum_o
);

  logic [15:0]                 sum_q, sum_d;
  logic [tcsum_pkg::IdxW-1:0]  idx_q, idx_d;
  logic                        mode_q, mode_d;
  logic                        out_valid_q, out_valid_d;
  logic [15:0]                 csum_q;
  logic [tcsum_pkg::IdxW-1:0]  idx_cur, pos;
  logic [15:0]                 base, word;

  // a word moves on only when the result register is free or is being read out
  assign take_o = stage_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    mode_d  = stage_i.first ? stage_i.op : mode_q;
    idx_cur = stage_i.first ? '0 : idx_q;
    base    = stage_i.first ? stage_i.phdr_sum : sum_q;
    pos     = (mode_d == tcsum_pkg::MODE_TCP) ? tcsum_pkg::TCP_CSUM_POS
                                              : tcsum_pkg::IP_CSUM_POS;
    word    = (idx_cur == pos) ? tcsum_pkg::ZERO16 : stage_i.data_word;
    if (stage_i.last && stage_i.odd_tail) begin
      word = word & tcsum_pkg::ODD_MASK;
    end
    sum_d = tcsum_pkg::oc_add(base, word);
    idx_d = (idx_cur < tcsum_pkg::IDX_SAT) ? idx_cur + 4'd1 : idx_cur;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o && stage_i.last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      idx_q       <= '0;
      mode_q      <= tcsum_pkg::MODE_IP;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        sum_q  <= sum_d;
        idx_q  <= idx_d;
        mode_q <= mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && stage_i.last) begin
      csum_q <= ~sum_d & tcsum_pkg::MASK16;
    end
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = csum_q;

endmodule

`default_nettype wire

// File: rtl/tcp_ip_checksum_engine.sv
// ----------------------------------------------------------------------------
// tcp_ip_checksum_engine
// Internet checksum over an IPv4 header or a TCP segment with pseudo-header.
// ----------------------------------------------------------------------------
// Takes one 16-bit packet word per cycle with no gaps needed between words or
// packets, unless the input side stalls. Each word passes through an input
// register (where the TCP pseudo-header is pre-folded on the first word) and
// then one 16-bit end-around add into the running sum; the checksum of a
// packet is valid in the result register once its last word has been added.
// The input side stalls only while a finished checksum waits in the result
// register and the next word in the input register is blocked behind it.
`timescale 1ns / 1ps
`default_nettype none

module tcp_ip_checksum_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic        first_i,
  input  wire logic [15:0] data_word_i,
  input  wire logic        last_i,
  input  wire logic        odd_tail_i,
  input  wire logic [31:0] src_addr_i,
  input  wire logic [31:0] dst_addr_i,
  input  wire logic [15:0] seg_len_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      checksum_o
);

  logic              take;
  logic              stage_valid;
  tcsum_pkg::stage_t stage;

  tcsum_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .first_i       (first_i),
    .data_word_i   (data_word_i),
    .last_i        (last_i),
    .odd_tail_i    (odd_tail_i),
    .src_addr_i    (src_addr_i),
    .dst_addr_i    (dst_addr_i),
    .seg_len_i     (seg_len_i),
    .take_i        (take),
    .stage_valid_o (stage_valid),
    .stage_o       (stage)
  );

  tcsum_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid),
    .stage_i       (stage),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .checksum_o    (checksum_o)
  );

`ifndef SYNTH
  // a blocked word stays put in the input register
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid && !take |=> stage_valid && $stable(stage))
    else $error("input register changed while stalled");

  // the last word of a packet always produces a checksum
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && stage.last |=> out_valid_o)
    else $error("no checksum after last word");

  // a pending checksum is never overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !take)
    else $error("word taken while result pending");
`endif

endmodule

`default_nettype wire
